// ===== src/qta_pkg.sv =====
// shared types, constants and the corner id table of the quarter-tile autotiler
// used by every module of the block; depends on nothing
`default_nettype none

package qta_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int CODE_BITS  = 8;

    localparam int X_BITS    = $clog2(MAX_WIDTH);
    localparam int Y_BITS    = $clog2(MAX_HEIGHT);
    localparam int SIZE_BITS = 7;
    localparam int LINE_ROWS = 3;
    localparam int SLOT_BITS = 2;

    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 7;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_HEIGHT = CFG_IDX_BITS'(1);

    // corner codes
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    // match pattern codes, column index into the id table
    localparam logic [2:0] SEL_NONE   = 3'd0;
    localparam logic [2:0] SEL_ALL    = 3'd1;
    localparam logic [2:0] SEL_NODIAG = 3'd2;
    localparam logic [2:0] SEL_VERT   = 3'd3;
    localparam logic [2:0] SEL_HORIZ  = 3'd4;

    typedef logic [CODE_BITS-1:0] t_code;
    typedef logic [X_BITS-1:0]    t_x;
    typedef logic [Y_BITS-1:0]    t_y;
    typedef logic [SIZE_BITS-1:0] t_size;
    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [4:0]           t_qid;

    // neighborhood codes, [row][column], centre at [1][1]
    typedef logic [2:0][2:0][CODE_BITS-1:0] t_nbhd;

    localparam t_qid CORNER_IDS [0:3][0:4] = '{
        '{5'd8,  5'd13, 5'd2, 5'd12, 5'd9},
        '{5'd11, 5'd14, 5'd3, 5'd15, 5'd10},
        '{5'd20, 5'd17, 5'd6, 5'd16, 5'd21},
        '{5'd23, 5'd18, 5'd7, 5'd19, 5'd22}
    };

    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        t_slot wr_slot;
        t_slot rd_slot_a;
        t_slot rd_slot_b;
        t_x    x;
    } t_lb_ctl;

    // which sides of the cell lie outside the map
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edges;

    typedef struct packed {
        t_qid br;
        t_qid bl;
        t_qid tr;
        t_qid tl;
    } t_quarters;

    function automatic t_qid pick_id(input logic [1:0] corner, input logic diag,
                                     input logic vert, input logic horiz);
        logic [2:0] sel;
        if (vert && horiz) begin
            sel = diag ? SEL_ALL : SEL_NODIAG;
        end else if (vert) begin
            sel = SEL_VERT;
        end else if (horiz) begin
            sel = SEL_HORIZ;
        end else begin
            sel = SEL_NONE;
        end
        return CORNER_IDS[corner][sel];
    endfunction

endpackage

`default_nettype wire

// ===== src/qta_line_buf.sv =====
// three-row line store of tile codes, one write and two registered reads per cycle
// depends on qta_pkg
`default_nettype none

module qta_line_buf (
    input  wire                   i_clk,
    input  qta_pkg::t_lb_ctl      i_ctl,
    input  wire  [qta_pkg::CODE_BITS-1:0] i_wr_data,
    output logic [qta_pkg::CODE_BITS-1:0] o_rd_a,
    output logic [qta_pkg::CODE_BITS-1:0] o_rd_b
);
    import qta_pkg::*;

    t_code mem [LINE_ROWS][MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_ctl.wr_slot][i_ctl.x] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_a <= mem[i_ctl.rd_slot_a][i_ctl.x];
            o_rd_b <= mem[i_ctl.rd_slot_b][i_ctl.x];
        end
    end

endmodule

`default_nettype wire

// ===== src/qta_quarter_pick.sv =====
// neighbor match and quarter id choice for one cell
// depends on qta_pkg
`default_nettype none

module qta_quarter_pick (
    input  qta_pkg::t_nbhd     i_nbhd,
    input  qta_pkg::t_edges    i_edges,
    output qta_pkg::t_quarters o_quarters
);
    import qta_pkg::*;

    logic [2:0][2:0] m;

    always_comb begin
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                m[dy][dx] = !(dy == 0 && i_edges.top) && !(dy == 2 && i_edges.bottom)
                         && !(dx == 0 && i_edges.left) && !(dx == 2 && i_edges.right)
                         && (i_nbhd[dy][dx] == i_nbhd[1][1]);
            end
        end
    end

    // diagonal, vertical, horizontal for each corner
    assign o_quarters.tl = pick_id(CORNER_TL, m[0][0], m[0][1], m[1][0]);
    assign o_quarters.tr = pick_id(CORNER_TR, m[0][2], m[0][1], m[1][2]);
    assign o_quarters.bl = pick_id(CORNER_BL, m[2][0], m[2][1], m[1][0]);
    assign o_quarters.br = pick_id(CORNER_BR, m[2][2], m[2][1], m[1][2]);

endmodule

`default_nettype wire

// ===== src/quarter_tile_autotiler.sv =====
// top level of the quarter-tile autotiler: counters, 3x3 window, result sequencer
// depends on qta_pkg, qta_line_buf and qta_quarter_pick
//
//  channel | dir | handshake              | word
//  --------+-----+------------------------+---------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready  | tile code of next cell, raster order
//  m       | out | o_m_tvalid/i_m_tready  | finished cell, ids, tlast, tuser
//  cfg     | in  | i_cfg_valid/o_cfg_ready| register index and value
//
// one word a cycle while the output is not stalled and an item finishes at most one cell;
// an item finishing several cells (two in the last column or last row, four at the map's
// final cell) has the result sequencer feed them one by one into the single output register
// pipeline: line read stage, window/sequencer stage, output register
// reset clears counters and valid flags and sets both sizes to one; the line store is
// never cleared
// a stalled output holds its word and the input keeps flowing until both stages fill
`default_nettype none

module quarter_tile_autotiler (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // slave side
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire  [qta_pkg::IN_DATA_BITS-1:0]     i_s_tdata,   // [7:0] tile_code
    // master side
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    // [5:0] cell_x, [11:6] cell_y, [16:12] quarter_top_left, [21:17] quarter_top_right,
    // [26:22] quarter_bottom_left, [31:27] quarter_bottom_right
    output logic [qta_pkg::OUT_DATA_BITS-1:0]    o_m_tdata,
    output logic                                 o_m_tlast,   // end_of_run
    output logic                                 o_m_tuser,   // [0] end_of_map
    // configuration
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [qta_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire  [qta_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import qta_pkg::*;

    // map size, kept clamped to 1..max
    t_size r_w, r_h;
    // position and line slot of the next input cell
    t_x    r_cx;
    t_y    r_cy;
    t_slot r_slot;

    logic cfg_wr, in_acc, x_end, y_end;
    t_slot slot_m1, slot_m2;

    // stage 1: accepted code, line reads in flight
    logic  r1_valid;
    t_code r1_code;
    t_x    r1_cx;
    t_y    r1_cy;
    t_code rd_a, rd_b;

    // stage 2: window and the list of cells this item finishes
    logic  r2_valid;
    t_x    r2_cx;
    t_y    r2_cy;
    logic  r2_xany, r2_x2, r2_xsel0;
    logic  r2_yany, r2_y2, r2_ysel0;
    logic  r2_ix, r2_iy;
    t_code r_win [3][3];   // [column][row], column 2 newest, row 2 current row

    logic  x1_end, y1_end;
    logic  s2_has, s2_last, s2_free, s1_move, out_free, out_load;
    logic  sel_x, sel_y;
    t_x    xv;
    t_y    yv;
    t_nbhd nbhd;
    t_edges edges;
    t_quarters quarters;
    t_lb_ctl lb_ctl;

    // output register
    logic      r_out_valid;
    t_x        r_out_x;
    t_y        r_out_y;
    t_quarters r_out_q;
    logic      r_out_last, r_out_map_end;

    function automatic t_size clamp_size(input logic [CFG_DATA_BITS-1:0] v,
                                         input t_size maxv);
        if (v == '0) begin
            return t_size'(1);
        end else if (v > CFG_DATA_BITS'(maxv)) begin
            return maxv;
        end else begin
            return t_size'(v);
        end
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && (i_cfg_index == REG_MAP_WIDTH ||
                                         i_cfg_index == REG_MAP_HEIGHT);
    assign in_acc      = i_s_tvalid && o_s_tready;

    assign x_end   = (t_size'(r_cx) == r_w - t_size'(1));
    assign y_end   = (t_size'(r_cy) == r_h - t_size'(1));
    // slots of rows cy-1 and cy-2, modulo three
    assign slot_m1 = (r_slot == '0) ? t_slot'(LINE_ROWS - 1) : r_slot - t_slot'(1);
    assign slot_m2 = (r_slot == t_slot'(LINE_ROWS - 1)) ? '0 : r_slot + t_slot'(1);

    // registers and raster counters; a register write restarts the map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= t_size'(1);
            r_h    <= t_size'(1);
            r_cx   <= '0;
            r_cy   <= '0;
            r_slot <= '0;
        end else if (cfg_wr) begin
            if (i_cfg_index == REG_MAP_WIDTH) begin
                r_w <= clamp_size(i_cfg_data, t_size'(MAX_WIDTH));
            end else begin
                r_h <= clamp_size(i_cfg_data, t_size'(MAX_HEIGHT));
            end
            r_cx   <= '0;
            r_cy   <= '0;
            r_slot <= '0;
        end else if (in_acc) begin
            if (x_end) begin
                r_cx <= '0;
                if (y_end) begin
                    r_cy   <= '0;
                    r_slot <= '0;
                end else begin
                    r_cy   <= r_cy + t_y'(1);
                    r_slot <= slot_m2;
                end
            end else begin
                r_cx <= r_cx + t_x'(1);
            end
        end
    end

    // write the new code, fetch the same column of the two rows above
    always_comb begin
        lb_ctl.wr_en     = in_acc;
        lb_ctl.rd_en     = in_acc;
        lb_ctl.wr_slot   = r_slot;
        lb_ctl.rd_slot_a = slot_m2;
        lb_ctl.rd_slot_b = slot_m1;
        lb_ctl.x         = r_cx;
    end

    qta_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_ctl     (lb_ctl),
        .i_wr_data (i_s_tdata[CODE_BITS-1:0]),
        .o_rd_a    (rd_a),
        .o_rd_b    (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (in_acc) begin
            r1_valid <= 1'b1;
        end else if (s1_move) begin
            r1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_code <= i_s_tdata[CODE_BITS-1:0];
            r1_cx   <= r_cx;
            r1_cy   <= r_cy;
        end
    end

    // handshake chain: output slot frees stage 2, which frees stage 1
    assign out_free   = !r_out_valid || i_m_tready;
    assign s2_has     = r2_xany && r2_yany;
    assign s2_last    = (r2_ix == r2_x2) && (r2_iy == r2_y2);
    assign out_load   = r2_valid && s2_has && out_free;
    assign s2_free    = !r2_valid || !s2_has || (s2_last && out_load);
    assign s1_move    = r1_valid && s2_free;
    assign o_s_tready = !r1_valid || s2_free;

    // which columns and rows the item finishes: previous one, and at the
    // last column or row also the current one with the outside beyond it
    assign x1_end = (t_size'(r1_cx) == r_w - t_size'(1));
    assign y1_end = (t_size'(r1_cy) == r_h - t_size'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r2_ix    <= 1'b0;
            r2_iy    <= 1'b0;
        end else if (s1_move) begin
            r2_valid <= 1'b1;
            r2_ix    <= 1'b0;
            r2_iy    <= 1'b0;
        end else if (s2_free) begin
            r2_valid <= 1'b0;
        end else if (out_load) begin
            if (r2_ix != r2_x2) begin
                r2_ix <= 1'b1;
            end else begin
                r2_ix <= 1'b0;
                r2_iy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r2_cx    <= r1_cx;
            r2_cy    <= r1_cy;
            r2_xany  <= x1_end || (r1_cx != '0);
            r2_x2    <= x1_end && (r_w != t_size'(1));
            r2_xsel0 <= x1_end && (r_w == t_size'(1));
            r2_yany  <= y1_end || (r1_cy != '0);
            r2_y2    <= y1_end && (r_h != t_size'(1));
            r2_ysel0 <= y1_end && (r_h == t_size'(1));
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= '{rd_a, rd_b, r1_code};
        end
    end

    // centre in window column 1 or 2, row 1 or 2
    assign sel_x = r2_xsel0 || r2_ix;
    assign sel_y = r2_ysel0 || r2_iy;
    assign xv    = sel_x ? r2_cx : r2_cx - t_x'(1);
    assign yv    = sel_y ? r2_cy : r2_cy - t_y'(1);

    always_comb begin
        edges.left   = (xv == '0);
        edges.right  = (t_size'(xv) == r_w - t_size'(1));
        edges.top    = (yv == '0);
        edges.bottom = (t_size'(yv) == r_h - t_size'(1));
    end

    // past the newest column or row lies the outside, masked by the edges
    always_comb begin
        logic [1:0] ci;
        logic [1:0] ri;
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                ci = 2'(dx) + {1'b0, sel_x};
                ri = 2'(dy) + {1'b0, sel_y};
                if (ci == 2'd3 || ri == 2'd3) begin
                    nbhd[dy][dx] = '0;
                end else begin
                    nbhd[dy][dx] = r_win[ci][ri];
                end
            end
        end
    end

    qta_quarter_pick u_quarter_pick (
        .i_nbhd     (nbhd),
        .i_edges    (edges),
        .o_quarters (quarters)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x       <= xv;
            r_out_y       <= yv;
            r_out_q       <= quarters;
            r_out_last    <= s2_last;
            r_out_map_end <= edges.right && edges.bottom;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_q.br, r_out_q.bl, r_out_q.tr, r_out_q.tl, r_out_y, r_out_x};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_map_end;

`ifndef NO_ASSERTIONS
    // the map's final cell is always the last word of its item
    a_map_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_map_end |-> r_out_last)
        else $error("end of map without end of run");

    // second column step only exists for a two-column list
    a_seq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid && (r2_ix || r2_iy) |-> (r2_ix ? r2_x2 : 1'b1) && (r2_iy ? r2_y2 : 1'b1))
        else $error("result sequencer ran past its list");

    // emitted cells stay inside the map
    a_cell_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (t_size'(r_out_x) < r_w) && (t_size'(r_out_y) < r_h))
        else $error("cell outside the map");

    // a register write restarts the raster position
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_cx == '0) && (r_cy == '0) && (r_slot == '0))
        else $error("register write did not restart the map");
`endif

endmodule

`default_nettype wire
